@@ sv/rtsi_pkg.sv @@
`default_nettype none

package rtsi_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       first;
    } char_item_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic [1:0]         status;
        logic [11:0]        stop_index;
    } result_item_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [11:0] STOP_MAX = 12'hFFF;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    localparam logic [5:0] BASE_AUTO = 6'd0;
    localparam logic [5:0] BASE_ONE  = 6'd1;
    localparam logic [5:0] BASE_OCT  = 6'd8;
    localparam logic [5:0] BASE_DEC  = 6'd10;
    localparam logic [5:0] BASE_HEX  = 6'd16;
    localparam logic [5:0] BASE_MAX  = 6'd36;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_CLAMP = 2'd1;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFFFFFFFFFFFFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000000000000000;
    localparam logic signed [63:0] S32_MAX = 64'sh000000007FFFFFFF;
    localparam logic signed [63:0] S32_MIN = 64'shFFFFFFFF80000000;

endpackage

`default_nettype wire

@@ sv/radix_text_to_signed_int.sv @@
// Channel   Direction  Handshake                   Payload
// char      in         char_valid / char_ready     rtsi_pkg::char_item_t
// result    out        result_valid / result_ready rtsi_pkg::result_item_t
// config    in         APB psel/penable/pwrite     base_setting (0x0), clamp_to_32 (0x4)
//
// One character transfer per cycle unless the input stalls; a character is held in the
// hold register and parsed from there, and a string's result goes to the result register.
// One parse step is a 64x6 multiply, an add and a limit compare.
// The input stalls only when a character ends a string while the result register
// still holds an untaken result.
// Reset clears the parser state and the valid flags, not the data registers.
`default_nettype none

module radix_text_to_signed_int #(
    parameter int unsigned MAX_LEN = 4095
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   char_valid,
    output logic                        char_ready,
    input  wire rtsi_pkg::char_item_t   char_data,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output rtsi_pkg::result_item_t      result_data,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int PW = $clog2(MAX_LEN + 1);
    localparam int SW = (PW > 12) ? PW : 12;
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_LEN);

    localparam logic [2:0] PH_DONE    = 3'd0;
    localparam logic [2:0] PH_SPACE   = 3'd1;
    localparam logic [2:0] PH_SIGNED  = 3'd2;
    localparam logic [2:0] PH_ZERO    = 3'd3;
    localparam logic [2:0] PH_HEXPEND = 3'd4;
    localparam logic [2:0] PH_DIGITS  = 3'd5;

    function automatic logic [6:0] digit_of(input logic [7:0] ch);
        logic [6:0] r;
        r = '0;
        if (ch >= rtsi_pkg::CH_ZERO && ch <= rtsi_pkg::CH_NINE)
        begin
            r = {1'b1, 6'(ch - rtsi_pkg::CH_ZERO)};
        end
        else if (ch >= rtsi_pkg::CH_UA && ch <= rtsi_pkg::CH_UZ)
        begin
            r = {1'b1, 6'(ch - rtsi_pkg::CH_UA + 8'd10)};
        end
        else if (ch >= rtsi_pkg::CH_LA && ch <= rtsi_pkg::CH_LZ)
        begin
            r = {1'b1, 6'(ch - rtsi_pkg::CH_LA + 8'd10)};
        end
        return r;
    endfunction

    logic [5:0] base_setting_reg;
    logic       clamp_reg;

    rtsi_pkg::char_item_t   hold_reg;
    logic                   hold_valid_reg, hold_valid_next;
    rtsi_pkg::result_item_t res_reg, res_next;
    logic                   res_valid_reg, res_valid_next;

    logic [2:0]    phase_reg, phase_next;
    logic          neg_reg, neg_next;
    logic [5:0]    biu_reg, biu_next;
    logic [63:0]   mag_reg, mag_next;
    logic          ovf_reg, ovf_next;
    logic [PW-1:0] pos_reg, pos_next;

    logic [2:0]    ph;
    logic          neg;
    logic [5:0]    biu;
    logic [63:0]   mag;
    logic          ovf;
    logic [PW-1:0] pos;
    logic [7:0]    c;
    logic [6:0]    dg;
    logic          dval;
    logic [5:0]    dv;
    logic [5:0]    b_sig;
    logic          chk_signed, chk_digits;
    logic [69:0]   prod;
    logic [70:0]   acc_sum;
    logic [70:0]   limit;

    logic                   emit;
    logic signed [63:0]     em_val;
    logic [1:0]             em_st;
    logic [PW-1:0]          em_stop;
    logic [SW-1:0]          stop_w;
    logic signed [63:0]     out_val;
    logic                   step_go;

    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        if (paddr[2])
        begin
            prdata = {31'b0, clamp_reg};
        end
        else
        begin
            prdata = {26'b0, base_setting_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_setting_reg <= '0;
            clamp_reg        <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case ({1'b0, paddr[2]})
                rtsi_pkg::REG_BASE:  base_setting_reg <= pwdata[5:0];
                rtsi_pkg::REG_CLAMP: clamp_reg        <= pwdata[0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        ph  = phase_reg;
        neg = neg_reg;
        biu = biu_reg;
        mag = mag_reg;
        ovf = ovf_reg;
        pos = pos_reg;
        c   = hold_reg.char_code;
        if (hold_reg.first)
        begin
            ph  = PH_SPACE;
            neg = 1'b0;
            biu = '0;
            mag = '0;
            ovf = 1'b0;
            pos = '0;
        end

        dg   = digit_of(c);
        dval = dg[6];
        dv   = dg[5:0];

        phase_next = ph;
        neg_next   = neg;
        biu_next   = biu;
        mag_next   = mag;
        ovf_next   = ovf;
        pos_next   = pos;

        emit    = 1'b0;
        em_val  = '0;
        em_st   = rtsi_pkg::ST_OK;
        em_stop = '0;

        chk_signed = 1'b0;
        chk_digits = 1'b0;

        b_sig = (base_setting_reg == rtsi_pkg::BASE_AUTO) ? rtsi_pkg::BASE_DEC
                                                           : base_setting_reg;
        prod    = 70'(mag) * 70'(biu);
        acc_sum = 71'(prod) + 71'(dv);
        limit   = neg ? 71'(64'h8000000000000000) : 71'(64'h7FFFFFFFFFFFFFFF);

        if (ph != PH_DONE)
        begin
            pos_next = (pos < POS_MAX) ? pos + PW'(1) : pos;
            unique case (ph)
                PH_SPACE:
                begin
                    if (c == rtsi_pkg::CH_NUL)
                    begin
                        emit  = 1'b1;
                        em_st = rtsi_pkg::ST_EMPTY;
                    end
                    else if (c == rtsi_pkg::CH_SPACE ||
                             (c >= rtsi_pkg::CH_TAB && c <= rtsi_pkg::CH_CR))
                    begin
                        phase_next = PH_SPACE;
                    end
                    else if (c == rtsi_pkg::CH_MINUS || c == rtsi_pkg::CH_PLUS)
                    begin
                        neg_next   = (c == rtsi_pkg::CH_MINUS);
                        phase_next = PH_SIGNED;
                    end
                    else
                    begin
                        chk_signed = 1'b1;
                    end
                end
                PH_SIGNED:
                begin
                    chk_signed = 1'b1;
                end
                PH_ZERO:
                begin
                    if (c == rtsi_pkg::CH_LX || c == rtsi_pkg::CH_UX)
                    begin
                        biu_next   = rtsi_pkg::BASE_HEX;
                        phase_next = PH_HEXPEND;
                    end
                    else
                    begin
                        chk_digits = 1'b1;
                    end
                end
                PH_HEXPEND:
                begin
                    if (dval && dv < rtsi_pkg::BASE_HEX)
                    begin
                        mag_next   = 64'(dv);
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        emit    = 1'b1;
                        em_stop = (pos >= POS_MAX) ? POS_MAX : pos - PW'(1);
                    end
                end
                PH_DIGITS:
                begin
                    chk_digits = 1'b1;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end

        if (chk_signed)
        begin
            if (base_setting_reg == rtsi_pkg::BASE_ONE ||
                base_setting_reg > rtsi_pkg::BASE_MAX)
            begin
                emit = 1'b1;
            end
            else if (c == rtsi_pkg::CH_ZERO &&
                     (base_setting_reg == rtsi_pkg::BASE_AUTO ||
                      base_setting_reg == rtsi_pkg::BASE_HEX))
            begin
                mag_next   = '0;
                biu_next   = (base_setting_reg == rtsi_pkg::BASE_HEX) ? rtsi_pkg::BASE_HEX
                                                                      : rtsi_pkg::BASE_OCT;
                phase_next = PH_ZERO;
            end
            else if (dval && dv < b_sig)
            begin
                biu_next   = b_sig;
                mag_next   = 64'(dv);
                phase_next = PH_DIGITS;
            end
            else
            begin
                emit = 1'b1;
            end
        end

        if (chk_digits)
        begin
            phase_next = PH_DIGITS;
            if (dval && dv < biu)
            begin
                if (!ovf)
                begin
                    if (biu == '0 || acc_sum > limit)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        mag_next = acc_sum[63:0];
                    end
                end
            end
            else
            begin
                emit    = 1'b1;
                em_stop = pos;
                if (ovf)
                begin
                    em_st  = rtsi_pkg::ST_RANGE;
                    em_val = neg ? rtsi_pkg::S64_MIN : rtsi_pkg::S64_MAX;
                end
                else
                begin
                    em_val = neg ? -$signed(mag) : $signed(mag);
                end
            end
        end

        if (emit)
        begin
            phase_next = PH_DONE;
        end
    end

    always_comb
    begin
        out_val = em_val;
        if (clamp_reg)
        begin
            if (em_val < rtsi_pkg::S32_MIN)
            begin
                out_val = rtsi_pkg::S32_MIN;
            end
            else if (em_val > rtsi_pkg::S32_MAX)
            begin
                out_val = rtsi_pkg::S32_MAX;
            end
        end
        stop_w = SW'(em_stop);
        res_next.value  = out_val;
        res_next.status = em_st;
        if (stop_w > SW'(rtsi_pkg::STOP_MAX))
        begin
            res_next.stop_index = rtsi_pkg::STOP_MAX;
        end
        else
        begin
            res_next.stop_index = stop_w[11:0];
        end
    end

    assign step_go    = hold_valid_reg & (~emit | ~res_valid_reg | result_ready);
    assign char_ready = ~hold_valid_reg | step_go;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (char_valid && char_ready)
        begin
            hold_valid_next = 1'b1;
        end
        else if (step_go)
        begin
            hold_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg & ~result_ready;
        if (step_go && emit)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            phase_reg      <= PH_DONE;
            neg_reg        <= 1'b0;
            biu_reg        <= '0;
            mag_reg        <= '0;
            ovf_reg        <= 1'b0;
            pos_reg        <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            res_valid_reg  <= res_valid_next;
            if (step_go)
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                biu_reg   <= biu_next;
                mag_reg   <= mag_next;
                ovf_reg   <= ovf_next;
                pos_reg   <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
        begin
            hold_reg <= char_data;
        end
        if (step_go && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result_data  = res_reg;

endmodule

`default_nettype wire

@@ sv/rtsi_checker.sv @@
`default_nettype none

module rtsi_checker (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   result_valid,
    input wire logic                   result_ready,
    input wire rtsi_pkg::result_item_t result_data
);

    // A stalled result transfer keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_data.status == rtsi_pkg::ST_OK ||
                         result_data.status == rtsi_pkg::ST_RANGE ||
                         result_data.status == rtsi_pkg::ST_EMPTY)
        else $error("undefined status code");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.status == rtsi_pkg::ST_EMPTY |->
            result_data.value == 64'sd0 && result_data.stop_index == 12'd0)
        else $error("empty string result not zero");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.status == rtsi_pkg::ST_RANGE |->
            result_data.value == rtsi_pkg::S64_MAX || result_data.value == rtsi_pkg::S64_MIN ||
            result_data.value == rtsi_pkg::S32_MAX || result_data.value == rtsi_pkg::S32_MIN)
        else $error("range error without saturated value");

endmodule

bind radix_text_to_signed_int rtsi_checker u_rtsi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
);

`default_nettype wire

@@ tb/radix_text_to_signed_int_tb.sv @@
`default_nettype none

module radix_text_to_signed_int_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned POS_LIMIT = 4095;
    localparam int unsigned NOT_DIGIT = 99;
    localparam int PLAN_LEN = 10;
    localparam int PHASE_ITEMS = 72;

    typedef enum logic [2:0] {
        PARSE_DONE,
        PARSE_SPACE,
        PARSE_SIGNED,
        PARSE_ZERO,
        PARSE_HEXPEND,
        PARSE_DIGITS
    } parse_phase_t;

    typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    class conversion_checker_t;
        logic [5:0]             radix_cfg;
        logic                   clamp_cfg;
        parse_phase_t           state;
        logic                   is_negative;
        logic [5:0]             radix;
        logic [63:0]            magnitude;
        logic                   saturated;
        int unsigned            cursor;
        rtsi_pkg::result_item_t expected_numbers[$];
        int                     errors;

        function new();
            radix_cfg = rtsi_pkg::BASE_AUTO;
            clamp_cfg = 1'b0;
            state = PARSE_DONE;
            is_negative = 1'b0;
            radix = '0;
            magnitude = '0;
            saturated = 1'b0;
            cursor = 0;
            errors = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] data);
            if (idx == rtsi_pkg::REG_BASE)
                radix_cfg = data[5:0];
            else if (idx == rtsi_pkg::REG_CLAMP)
                clamp_cfg = data[0];
        endfunction

        function int pending();
            return expected_numbers.size();
        endfunction

        function int unsigned digit_value(logic [7:0] c);
            if (c >= rtsi_pkg::CH_ZERO && c <= rtsi_pkg::CH_NINE)
                return int'(c - rtsi_pkg::CH_ZERO);
            if (c >= rtsi_pkg::CH_UA && c <= rtsi_pkg::CH_UZ)
                return int'(c - rtsi_pkg::CH_UA) + 10;
            if (c >= rtsi_pkg::CH_LA && c <= rtsi_pkg::CH_LZ)
                return int'(c - rtsi_pkg::CH_LA) + 10;
            return NOT_DIGIT;
        endfunction

        function logic is_blank(logic [7:0] c);
            return c == rtsi_pkg::CH_SPACE || (c >= rtsi_pkg::CH_TAB && c <= rtsi_pkg::CH_CR);
        endfunction

        function void post_number(logic signed [63:0] v, logic [1:0] st, int unsigned stop);
            rtsi_pkg::result_item_t item;
            if (clamp_cfg)
            begin
                if (v < rtsi_pkg::S32_MIN)
                    v = rtsi_pkg::S32_MIN;
                else if (v > rtsi_pkg::S32_MAX)
                    v = rtsi_pkg::S32_MAX;
            end
            item.value = v;
            item.status = st;
            item.stop_index = (stop > int'(rtsi_pkg::STOP_MAX)) ? rtsi_pkg::STOP_MAX : 12'(stop);
            expected_numbers.push_back(item);
            state = PARSE_DONE;
        endfunction

        function void add_digit(int unsigned d);
            logic [63:0] limit;
            limit = is_negative ? 64'(rtsi_pkg::S64_MIN) : 64'(rtsi_pkg::S64_MAX);
            if (saturated)
                return;
            if (radix == 0 || magnitude > (limit - 64'(d)) / 64'(radix))
            begin
                saturated = 1'b1;
                return;
            end
            magnitude = magnitude * 64'(radix) + 64'(d);
        endfunction

        function void close_number(int unsigned p);
            if (saturated)
                post_number(is_negative ? rtsi_pkg::S64_MIN : rtsi_pkg::S64_MAX,
                            rtsi_pkg::ST_RANGE, p);
            else
                post_number(is_negative ? 64'(0) - magnitude : magnitude, rtsi_pkg::ST_OK, p);
        endfunction

        function void parse_char(rtsi_pkg::char_item_t item);
            logic [7:0]  c;
            int unsigned p;
            int unsigned d;
            int unsigned b;
            c = item.char_code;
            if (item.first)
            begin
                state = PARSE_SPACE;
                is_negative = 1'b0;
                radix = '0;
                magnitude = '0;
                saturated = 1'b0;
                cursor = 0;
            end
            if (state == PARSE_DONE)
                return;
            p = cursor;
            if (cursor < POS_LIMIT)
                cursor++;
            d = digit_value(c);

            if (state == PARSE_SPACE)
            begin
                if (c == rtsi_pkg::CH_NUL)
                begin
                    post_number('0, rtsi_pkg::ST_EMPTY, 0);
                    return;
                end
                if (is_blank(c))
                    return;
                if (c == rtsi_pkg::CH_MINUS || c == rtsi_pkg::CH_PLUS)
                begin
                    is_negative = (c == rtsi_pkg::CH_MINUS);
                    state = PARSE_SIGNED;
                    return;
                end
                state = PARSE_SIGNED;
            end

            case (state)
                PARSE_SIGNED:
                begin
                    if (radix_cfg == rtsi_pkg::BASE_ONE || radix_cfg > rtsi_pkg::BASE_MAX)
                    begin
                        post_number('0, rtsi_pkg::ST_OK, 0);
                        return;
                    end
                    if (c == rtsi_pkg::CH_ZERO &&
                        (radix_cfg == rtsi_pkg::BASE_AUTO || radix_cfg == rtsi_pkg::BASE_HEX))
                    begin
                        magnitude = '0;
                        radix = (radix_cfg == rtsi_pkg::BASE_HEX) ? rtsi_pkg::BASE_HEX
                                                                  : rtsi_pkg::BASE_OCT;
                        state = PARSE_ZERO;
                        return;
                    end
                    b = (radix_cfg == rtsi_pkg::BASE_AUTO) ? rtsi_pkg::BASE_DEC : radix_cfg;
                    if (d < b)
                    begin
                        radix = 6'(b);
                        magnitude = 64'(d);
                        state = PARSE_DIGITS;
                        return;
                    end
                    post_number('0, rtsi_pkg::ST_OK, 0);
                    return;
                end
                PARSE_ZERO:
                begin
                    if (c == rtsi_pkg::CH_LX || c == rtsi_pkg::CH_UX)
                    begin
                        radix = rtsi_pkg::BASE_HEX;
                        state = PARSE_HEXPEND;
                        return;
                    end
                    state = PARSE_DIGITS;
                end
                PARSE_HEXPEND:
                begin
                    if (d < rtsi_pkg::BASE_HEX)
                    begin
                        magnitude = 64'(d);
                        state = PARSE_DIGITS;
                        return;
                    end
                    post_number('0, rtsi_pkg::ST_OK, (p >= POS_LIMIT) ? POS_LIMIT : p - 1);
                    return;
                end
                default:
                begin
                end
            endcase

            if (state == PARSE_DIGITS)
            begin
                if (d < radix)
                begin
                    add_digit(d);
                    return;
                end
                close_number(p);
            end
        endfunction

        function void compare_result(rtsi_pkg::result_item_t got);
            rtsi_pkg::result_item_t want;
            if (expected_numbers.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual value %0d status %0d",
                         $time, got.value, got.status);
                errors++;
                return;
            end
            want = expected_numbers.pop_front();
            if (got.value !== want.value)
            begin
                $display("%0t: value mismatch, expected %0d, actual %0d",
                         $time, want.value, got.value);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.stop_index !== want.stop_index)
            begin
                $display("%0t: stop index mismatch, expected %0d, actual %0d",
                         $time, want.stop_index, got.stop_index);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   char_valid = 1'b0;
    logic                   char_ready;
    rtsi_pkg::char_item_t   char_data = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    rtsi_pkg::result_item_t result_data;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [2:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    conversion_checker_t sb;
    logic [7:0]  line_chars[$];
    logic [5:0]  cfg_base = rtsi_pkg::BASE_AUTO;
    int          burst_left = 0;
    int          chars_accepted = 0;
    int          plan_step = -1;
    logic        rx_hold = 1'b0;
    rx_mode_t    rx_mode = RX_ALWAYS;
    int          rx_left = 0;

    logic [5:0] base_plan [PLAN_LEN] = '{rtsi_pkg::BASE_AUTO, rtsi_pkg::BASE_DEC,
                                         rtsi_pkg::BASE_HEX, 6'd2, rtsi_pkg::BASE_MAX,
                                         rtsi_pkg::BASE_OCT, 6'd63, rtsi_pkg::BASE_ONE,
                                         rtsi_pkg::BASE_AUTO, 6'd37};
    logic       clamp_plan [PLAN_LEN] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
                                          1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

    radix_text_to_signed_int i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_data    (char_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin : rx_pattern
        logic take;
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 96);
        end
        else
        begin
            rx_left = rx_left - 1;
        end
        case (rx_mode)
            RX_ALWAYS:   take = 1'b1;
            RX_HALF:     take = 1'($urandom_range(0, 1));
            RX_SPARSE:   take = ($urandom_range(0, 3) == 0);
            default:     take = rx_left[2];
        endcase
        result_ready <= take && !rx_hold;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.compare_result(result_data);
    end

    task automatic send_item(input logic [7:0] code, input logic is_first);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                char_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        char_valid <= 1'b1;
        char_data <= '{char_code: code, first: is_first};
        do @(posedge clk); while (!char_ready);
        sb.parse_char(char_data);
        chars_accepted++;
    endtask

    task automatic send_line();
        foreach (line_chars[i])
            send_item(line_chars[i], i == 0);
    endtask

    task automatic load_line(input string s);
        line_chars.delete();
        for (int i = 0; i < s.len(); i++)
            line_chars.push_back(s[i]);
    endtask

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10)
            return rtsi_pkg::CH_ZERO + 8'(d);
        return (($urandom_range(0, 1) != 0) ? rtsi_pkg::CH_UA : rtsi_pkg::CH_LA) + 8'(d - 10);
    endfunction

    task automatic push_number(input logic [63:0] v, input int radix);
        logic [7:0] digs[$];
        do
        begin
            digs.push_front(digit_char(int'(v % 64'(radix))));
            v = v / 64'(radix);
        end while (v != 0);
        foreach (digs[i])
            line_chars.push_back(digs[i]);
    endtask

    task automatic build_line();
        int          radix;
        int          pick;
        logic [63:0] v;
        line_chars.delete();
        if ($urandom_range(0, 15) == 0)
        begin
            repeat ($urandom_range(1, 12))
                line_chars.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0)
        begin
            pick = $urandom_range(0, 5);
            line_chars.push_back((pick == 5) ? rtsi_pkg::CH_SPACE : rtsi_pkg::CH_TAB + 8'(pick));
        end
        pick = $urandom_range(0, 4);
        if (pick < 2)
            line_chars.push_back(rtsi_pkg::CH_MINUS);
        else if (pick == 2)
            line_chars.push_back(rtsi_pkg::CH_PLUS);

        radix = cfg_base;
        if (cfg_base == rtsi_pkg::BASE_AUTO || cfg_base == rtsi_pkg::BASE_HEX)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    line_chars.push_back(rtsi_pkg::CH_ZERO);
                    line_chars.push_back(($urandom_range(0, 1) != 0) ? rtsi_pkg::CH_LX
                                                                     : rtsi_pkg::CH_UX);
                    radix = rtsi_pkg::BASE_HEX;
                end
                1:
                begin
                    line_chars.push_back(rtsi_pkg::CH_ZERO);
                    radix = (cfg_base == rtsi_pkg::BASE_HEX) ? rtsi_pkg::BASE_HEX
                                                             : rtsi_pkg::BASE_OCT;
                end
                default:
                    radix = (cfg_base == rtsi_pkg::BASE_HEX) ? rtsi_pkg::BASE_HEX
                                                             : rtsi_pkg::BASE_DEC;
            endcase
        end
        if (radix < 2 || radix > rtsi_pkg::BASE_MAX)
            radix = $urandom_range(2, rtsi_pkg::BASE_MAX);

        case ($urandom_range(0, 5))
            0:
            begin
                pick = $urandom_range(0, 4);
                case (pick)
                    0:       v = 64'(rtsi_pkg::S64_MAX);
                    1:       v = 64'(rtsi_pkg::S64_MIN);
                    2:       v = 64'(rtsi_pkg::S64_MIN) + 64'd1;
                    default: v = '1;
                endcase
                push_number(v, radix);
                if (pick == 4)
                    line_chars.push_back(digit_char($urandom_range(0, radix - 1)));
            end
            1:
                repeat ($urandom_range(15, 70))
                    line_chars.push_back(digit_char($urandom_range(0, radix - 1)));
            default:
                repeat ($urandom_range(0, 6))
                    line_chars.push_back(digit_char($urandom_range(0, radix - 1)));
        endcase

        case ($urandom_range(0, 3))
            0:       line_chars.push_back(rtsi_pkg::CH_NUL);
            1:       line_chars.push_back(rtsi_pkg::CH_SPACE);
            default: line_chars.push_back(8'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(0, 9) == 0 && line_chars.size() > 1)
            repeat ($urandom_range(1, line_chars.size() - 1))
                void'(line_chars.pop_back());
    endtask

    task automatic drain();
        char_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(idx) << 2;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_register(idx, data);
    endtask

    task automatic set_config(input logic [5:0] radix_sel, input logic clamp);
        apb_write(rtsi_pkg::REG_BASE, 32'(radix_sel));
        apb_write(rtsi_pkg::REG_CLAMP, 32'(clamp));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_base = radix_sel;
    endtask

    initial
    begin
        wait (plan_step == 1);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (500) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #(5_000_000);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int start;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty text, then a character while no text is open.
        send_item(rtsi_pkg::CH_NUL, 1'b1);
        send_item(rtsi_pkg::CH_UA, 1'b0);
        load_line(" -0xg");
        send_line();
        load_line("+z");
        send_line();
        load_line("017,");
        send_line();
        // An unfinished text is abandoned by the next one.
        load_line("12");
        send_line();
        load_line("\t7f");
        line_chars.push_back(rtsi_pkg::CH_NUL);
        send_line();
        send_item(8'hFF, 1'b1);
        load_line("0X1a");
        line_chars.push_back(rtsi_pkg::CH_CR);
        send_line();

        load_line("-9223372036854775808");
        line_chars.push_back(rtsi_pkg::CH_NUL);
        send_line();

        for (int s = 0; s <= PLAN_LEN; s++)
        begin
            drain();
            if (s < PLAN_LEN)
                set_config(base_plan[s], clamp_plan[s]);
            else
                set_config(6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
            plan_step = s;
            start = chars_accepted;
            while (chars_accepted - start < PHASE_ITEMS)
            begin
                build_line();
                send_line();
                if ($urandom_range(0, 7) == 0)
                    send_item(8'($urandom_range(0, 255)), 1'b0);
            end
        end

        drain();
        repeat (6) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
